/* rtl/lru_session_table_core_defines.svh */
// ----------------------------------------------------------------------------
// lru_session_table_core_defines
// Assertion macros for the session table core.
// ----------------------------------------------------------------------------
`ifndef LRU_SESSION_TABLE_CORE_DEFINES_SVH
`define LRU_SESSION_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lst_pkg.sv */
// ----------------------------------------------------------------------------
// lst_pkg
// Shared constants, command codes and types of the LRU session table.
// ----------------------------------------------------------------------------
`default_nettype none

package lst_pkg;

   localparam int LST_MAX_ENTRIES = 16;

   localparam int COMMAND_W  = 2;
   localparam int KEY_WORD_W = 64;
   localparam int KEY_W      = 4 * KEY_WORD_W;
   localparam int STAMP_W    = 64;
   localparam int CAPACITY_W = 5;

   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = CAPACITY_W'(16);

   localparam logic [COMMAND_W-1:0] CMD_FIND   = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_GET    = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_REMOVE = 2'd2;

   // Port enables of the entry store.
   typedef struct packed {
      logic rd_en;
      logic wr_key_en;
      logic wr_stamp_en;
   } store_ctl_type;

endpackage

`default_nettype wire

/* rtl/lst_store.sv */
// ----------------------------------------------------------------------------
// lst_store
// Key and use-stamp memories: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_store import lst_pkg::*; #(
   parameter int MaxEntries = LST_MAX_ENTRIES,
   parameter int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1
) (
   input  wire logic                clock,
   input  wire store_ctl_type       ctl,
   input  wire logic [IdxW-1:0]     rd_addr,
   input  wire logic [IdxW-1:0]     wr_addr,
   input  wire logic [KEY_W-1:0]    wr_key,
   input  wire logic [STAMP_W-1:0]  wr_stamp,
   output logic      [KEY_W-1:0]    rd_key,
   output logic      [STAMP_W-1:0]  rd_stamp
);

   logic [KEY_W-1:0]   key_mem   [MaxEntries];
   logic [STAMP_W-1:0] stamp_mem [MaxEntries];

   always_ff @(posedge clock) begin
      if (ctl.wr_key_en) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (ctl.wr_stamp_en) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_key   <= key_mem[rd_addr];
         rd_stamp <= stamp_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/lru_session_table_core.sv */
// ----------------------------------------------------------------------------
// lru_session_table_core
// Fully associative session key table with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One item at a time. Every command scans all stored entries through the
// single read port of the entry memory, one entry per cycle, then passes
// through the decide and finish states (and the move-write state for a
// remove that moves the last entry). The next item is accepted while a
// result still waits on the rsp side. The memories need no clearing after
// reset; only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_session_table_core_defines.svh"

module lru_session_table_core import lst_pkg::*; #(
   parameter int MaxEntries = LST_MAX_ENTRIES,
   parameter int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CAPACITY_W-1:0]  csr_wr_data,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [COMMAND_W-1:0]   req_command,
   input  wire logic [KEY_WORD_W-1:0]  req_key_word0,
   input  wire logic [KEY_WORD_W-1:0]  req_key_word1,
   input  wire logic [KEY_WORD_W-1:0]  req_key_word2,
   input  wire logic [KEY_WORD_W-1:0]  req_key_word3,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_hit,
   output logic      [IdxW-1:0]        rsp_slot,
   output logic                        rsp_created,
   output logic                        rsp_evicted,
   output logic                        rsp_moved,
   output logic      [IdxW-1:0]        rsp_moved_from
);

   localparam int CntW = $clog2(MaxEntries + 1);
   localparam int CmpW = (CntW > CAPACITY_W) ? CntW : CAPACITY_W;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SCAN    = 3'd1;
   localparam logic [2:0] ST_DECIDE  = 3'd2;
   localparam logic [2:0] ST_MOVE_WR = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CAPACITY_W-1:0] capacity_ff;
   logic [COMMAND_W-1:0]  cmd_ff, cmd_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [CntW-1:0]       rd_idx_ff, rd_idx_in;
   logic                  dv_ff, dv_in;
   logic [IdxW-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                  found_ff, found_in;
   logic [IdxW-1:0]       found_idx_ff, found_idx_in;
   logic [IdxW-1:0]       best_idx_ff, best_idx_in;
   logic [STAMP_W-1:0]    best_stamp_ff, best_stamp_in;
   logic [CntW-1:0]       entry_count_ff, entry_count_in;
   logic [STAMP_W-1:0]    use_clock_ff, use_clock_in;

   logic                  res_hit_ff, res_hit_in;
   logic [IdxW-1:0]       res_slot_ff, res_slot_in;
   logic                  res_created_ff, res_created_in;
   logic                  res_evicted_ff, res_evicted_in;
   logic                  res_moved_ff, res_moved_in;
   logic [IdxW-1:0]       res_from_ff, res_from_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [IdxW-1:0]       rsp_slot_ff, rsp_slot_in;
   logic                  rsp_created_ff, rsp_created_in;
   logic                  rsp_evicted_ff, rsp_evicted_in;
   logic                  rsp_moved_ff, rsp_moved_in;
   logic [IdxW-1:0]       rsp_from_ff, rsp_from_in;

   store_ctl_type         st_ctl;
   logic [IdxW-1:0]       st_rd_addr;
   logic [IdxW-1:0]       st_wr_addr;
   logic [KEY_W-1:0]      st_wr_key;
   logic [STAMP_W-1:0]    st_wr_stamp;
   logic [KEY_W-1:0]      st_rd_key;
   logic [STAMP_W-1:0]    st_rd_stamp;

   logic [CAPACITY_W-1:0] cap_lo;
   logic                  append_ok;
   logic [CntW-1:0]       last_cnt;
   logic [IdxW-1:0]       last_idx;
   logic [IdxW-1:0]       dest_idx;

   lst_store #(
      .MaxEntries (MaxEntries),
      .IdxW       (IdxW)
   ) u_store (
      .clock    (clock),
      .ctl      (st_ctl),
      .rd_addr  (st_rd_addr),
      .wr_addr  (st_wr_addr),
      .wr_key   (st_wr_key),
      .wr_stamp (st_wr_stamp),
      .rd_key   (st_rd_key),
      .rd_stamp (st_rd_stamp)
   );

   // A capacity of zero acts as one; anything above the table size as full size.
   assign cap_lo    = (capacity_ff == '0) ? CAPACITY_W'(1) : capacity_ff;
   assign append_ok = (CmpW'(entry_count_ff) < CmpW'(cap_lo)) &&
                      (CmpW'(entry_count_ff) < CmpW'(MaxEntries));
   assign last_cnt  = entry_count_ff - CntW'(1);
   assign last_idx  = last_cnt[IdxW-1:0];
   assign dest_idx  = append_ok ? entry_count_ff[IdxW-1:0] : best_idx_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      rd_idx_in      = rd_idx_ff;
      dv_in          = 1'b0;
      cmp_idx_in     = rd_idx_ff[IdxW-1:0];
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      best_idx_in    = best_idx_ff;
      best_stamp_in  = best_stamp_ff;
      entry_count_in = entry_count_ff;
      use_clock_in   = use_clock_ff;
      res_hit_in     = res_hit_ff;
      res_slot_in    = res_slot_ff;
      res_created_in = res_created_ff;
      res_evicted_in = res_evicted_ff;
      res_moved_in   = res_moved_ff;
      res_from_in    = res_from_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_created_in = rsp_created_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_moved_in   = rsp_moved_ff;
      rsp_from_in    = rsp_from_ff;
      st_ctl         = '0;
      st_rd_addr     = rd_idx_ff[IdxW-1:0];
      st_wr_addr     = found_idx_ff;
      st_wr_key      = key_ff;
      st_wr_stamp    = use_clock_ff + STAMP_W'(1);

      // Compare the entry read in the previous cycle.
      if (dv_ff) begin
         if ((st_rd_key == key_ff) && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = cmp_idx_ff;
         end
         if ((cmp_idx_ff == '0) || (st_rd_stamp < best_stamp_ff)) begin
            best_idx_in   = cmp_idx_ff;
            best_stamp_in = st_rd_stamp;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_command;
               key_in    = {req_key_word3, req_key_word2, req_key_word1, req_key_word0};
               rd_idx_in = '0;
               found_in  = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff < entry_count_ff) begin
               st_ctl.rd_en = 1'b1;
               dv_in        = 1'b1;
               rd_idx_in    = rd_idx_ff + CntW'(1);
            end else if (!dv_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_hit_in     = 1'b0;
            res_slot_in    = '0;
            res_created_in = 1'b0;
            res_evicted_in = 1'b0;
            res_moved_in   = 1'b0;
            res_from_in    = '0;
            state_in       = ST_FINISH;
            case (cmd_ff)
               CMD_FIND, CMD_GET: begin
                  if (found_ff) begin
                     st_ctl.wr_stamp_en = 1'b1;
                     use_clock_in       = st_wr_stamp;
                     res_hit_in         = 1'b1;
                     res_slot_in        = found_idx_ff;
                  end else if (cmd_ff == CMD_GET) begin
                     st_wr_addr         = dest_idx;
                     st_ctl.wr_key_en   = 1'b1;
                     st_ctl.wr_stamp_en = 1'b1;
                     use_clock_in       = st_wr_stamp;
                     if (append_ok) begin
                        entry_count_in = entry_count_ff + CntW'(1);
                     end
                     res_created_in = 1'b1;
                     res_evicted_in = !append_ok;
                     res_slot_in    = dest_idx;
                  end
               end
               CMD_REMOVE: begin
                  if (found_ff) begin
                     res_hit_in  = 1'b1;
                     res_slot_in = found_idx_ff;
                     if (CntW'(found_idx_ff) < last_cnt) begin
                        // Fetch the last entry; it fills the hole next cycle.
                        st_ctl.rd_en = 1'b1;
                        st_rd_addr   = last_idx;
                        res_moved_in = 1'b1;
                        res_from_in  = last_idx;
                        state_in     = ST_MOVE_WR;
                     end else begin
                        entry_count_in = last_cnt;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_MOVE_WR: begin
            st_wr_key          = st_rd_key;
            st_wr_stamp        = st_rd_stamp;
            st_ctl.wr_key_en   = 1'b1;
            st_ctl.wr_stamp_en = 1'b1;
            entry_count_in     = last_cnt;
            state_in           = ST_FINISH;
         end
         ST_FINISH: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = res_hit_ff;
               rsp_slot_in    = res_slot_ff;
               rsp_created_in = res_created_ff;
               rsp_evicted_in = res_evicted_ff;
               rsp_moved_in   = res_moved_ff;
               rsp_from_in    = res_from_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         capacity_ff    <= CAPACITY_RESET;
         entry_count_ff <= '0;
         use_clock_ff   <= '0;
         dv_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         use_clock_ff   <= use_clock_in;
         dv_ff          <= dv_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      rd_idx_ff      <= rd_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      found_ff       <= found_in;
      found_idx_ff   <= found_idx_in;
      best_idx_ff    <= best_idx_in;
      best_stamp_ff  <= best_stamp_in;
      res_hit_ff     <= res_hit_in;
      res_slot_ff    <= res_slot_in;
      res_created_ff <= res_created_in;
      res_evicted_ff <= res_evicted_in;
      res_moved_ff   <= res_moved_in;
      res_from_ff    <= res_from_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_created_ff <= rsp_created_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_moved_ff   <= rsp_moved_in;
      rsp_from_ff    <= rsp_from_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_created    = rsp_created_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign rsp_moved      = rsp_moved_ff;
   assign rsp_moved_from = rsp_from_ff;

   `LST_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_valid && req_ready, state_ff == ST_SCAN, "accepted item did not start a scan")
   `LST_ASSERT_IMP(a_decide_after_drain, clock, reset, state_ff == ST_DECIDE, !dv_ff, "decision taken with a read still in flight")
   `LST_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, entry_count_ff <= CntW'(MaxEntries), "entry count above table size")
   `LST_ASSERT_IMP(a_evict_is_create, clock, reset, rsp_valid_ff && (rsp_evicted_ff || rsp_moved_ff), rsp_evicted_ff ? (rsp_created_ff && !rsp_hit_ff) : rsp_hit_ff, "inconsistent result flags")

endmodule

`default_nettype wire
